// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int PRIO_BITS_DEF = 16;

	localparam int ITEM_W    = 8;
	localparam int IN_PRIO_W = 16;
	localparam int STATUS_W  = 2;
	localparam int FILL_W    = 5;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 16;

	localparam logic [ITEM_W-1:0] EMPTY_ITEM = 8'h20;

	typedef enum logic [0:0] {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

// ===== design/sorted_priority_queue_core.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one enqueue or dequeue per cycle while s_tready is high; every cell compares and shifts in parallel.
// s_tready drops only while a result beat waits and m_tready is low.
// Reset clears the entry count and the output valid; cell contents stay undefined.
module sorted_priority_queue_core #(
	parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [spq_pkg::S_DATA_W-1:0]   s_tdata,  // item_in[7:0], priority_in[23:8]
	input  logic [0:0]                     s_tuser,  // cmd[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [spq_pkg::M_DATA_W-1:0]   m_tdata   // item_out[7:0], status[9:8], fill_count[14:10], zero[15]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                                accept;
	spq_pkg::cmd_t                       cmd;
	logic [spq_pkg::ITEM_W-1:0]          in_item;
	logic signed [spq_pkg::IN_PRIO_W-1:0] in_prio;
	logic signed [PRIORITY_BITS-1:0]     new_prio;
	logic                                full;
	logic                                empty;
	spq_pkg::cell_ctrl_t                 ctrl;

	logic [CNT_W-1:0]                    count_q;
	logic [CNT_W-1:0]                    count_d;

	logic                                out_valid_q;
	logic [spq_pkg::ITEM_W-1:0]          out_item_q;
	spq_pkg::status_t                    out_status_q;
	logic [spq_pkg::FILL_W-1:0]          out_fill_q;

	logic [spq_pkg::ITEM_W-1:0]          item_w [CAPACITY];
	logic signed [PRIORITY_BITS-1:0]     prio_w [CAPACITY];
	logic                                stay_w [CAPACITY];

	assign cmd      = spq_pkg::cmd_t'(s_tuser);
	assign in_item  = s_tdata[7:0];
	assign in_prio  = s_tdata[23:8];
	assign new_prio = PRIORITY_BITS'(in_prio);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	assign ctrl.ins = accept && (cmd == spq_pkg::CMD_ENQ) && !full;
	assign ctrl.del = accept && (cmd == spq_pkg::CMD_DEQ) && !empty;

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                            occ;
			logic                            prev_stay;
			logic [spq_pkg::ITEM_W-1:0]      prev_item;
			logic signed [PRIORITY_BITS-1:0] prev_prio;
			logic [spq_pkg::ITEM_W-1:0]      next_item;
			logic signed [PRIORITY_BITS-1:0] next_prio;

			assign occ = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign prev_stay = 1'b0;
				assign prev_item = in_item;
				assign prev_prio = new_prio;
			end else begin : g_mid
				assign prev_stay = stay_w[gi-1];
				assign prev_item = item_w[gi-1];
				assign prev_prio = prio_w[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign next_item = item_w[gi];
				assign next_prio = prio_w[gi];
			end else begin : g_inner
				assign next_item = item_w[gi+1];
				assign next_prio = prio_w[gi+1];
			end

			spq_cell #(
				.PRIO_BITS (PRIORITY_BITS),
				.IS_HEAD   (gi == 0)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ),
				.new_item  (in_item),
				.new_prio  (new_prio),
				.prev_stay (prev_stay),
				.prev_item (prev_item),
				.prev_prio (prev_prio),
				.next_item (next_item),
				.next_prio (next_prio),
				.item_q    (item_w[gi]),
				.prio_q    (prio_w[gi]),
				.stay      (stay_w[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_fill_q <= spq_pkg::FILL_W'(count_d);
			if (cmd == spq_pkg::CMD_DEQ) begin
				if (empty) begin
					out_item_q   <= spq_pkg::EMPTY_ITEM;
					out_status_q <= spq_pkg::ST_EMPTY;
				end else begin
					out_item_q   <= item_w[0];
					out_status_q <= spq_pkg::ST_OK;
				end
			end else begin
				out_item_q   <= '0;
				out_status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_fill_q, out_status_q, out_item_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_del_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.del))
		else $error("insert and remove in the same cycle");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not bump count");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (prio_w[0] <= prio_w[1]))
		else $error("head cells out of order");

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == spq_pkg::CMD_DEQ) && empty) |=>
		(out_status_q == spq_pkg::ST_EMPTY && count_q == '0))
		else $error("dequeue from empty mishandled");

endmodule

// ===== design/spq_cell.sv =====
// One storage cell of the sorted chain: holds an item and its priority.
module spq_cell #(
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
	parameter bit IS_HEAD   = 1'b0
) (
	input  logic                             clk,
	input  spq_pkg::cell_ctrl_t              ctrl,
	input  logic                             occ,
	input  logic [spq_pkg::ITEM_W-1:0]       new_item,
	input  logic signed [PRIO_BITS-1:0]      new_prio,
	input  logic                             prev_stay,
	input  logic [spq_pkg::ITEM_W-1:0]       prev_item,
	input  logic signed [PRIO_BITS-1:0]      prev_prio,
	input  logic [spq_pkg::ITEM_W-1:0]       next_item,
	input  logic signed [PRIO_BITS-1:0]      next_prio,
	output logic [spq_pkg::ITEM_W-1:0]       item_q,
	output logic signed [PRIO_BITS-1:0]      prio_q,
	output logic                             stay
);

	logic ge;
	logic gt;
	logic take_new;

	assign ge = (new_prio >= prio_q);
	assign gt = (new_prio > prio_q);
	// head keeps its entry on a tie, every other cell yields on a tie
	assign stay = occ && (IS_HEAD ? ge : gt);
	assign take_new = IS_HEAD || prev_stay;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !stay) begin
			if (take_new) begin
				item_q <= new_item;
				prio_q <= new_prio;
			end else begin
				item_q <= prev_item;
				prio_q <= prev_prio;
			end
		end else if (ctrl.del) begin
			item_q <= next_item;
			prio_q <= next_prio;
		end
	end

endmodule

// ===== test/sorted_priority_queue_core_tb.sv =====
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

	localparam int CAPACITY  = spq_pkg::CAPACITY_DEF;
	localparam int RAND_BEATS = 1325;
	localparam int HOLD_OFF  = 300;

	typedef struct packed {
		logic [spq_pkg::ITEM_W-1:0] item_out;
		spq_pkg::status_t           status;
		logic [spq_pkg::FILL_W-1:0] fill;
	} result_t;

	typedef struct {
		spq_pkg::cmd_t                         cmd;
		logic [spq_pkg::ITEM_W-1:0]            item;
		logic signed [spq_pkg::IN_PRIO_W-1:0]  prio;
		bit                                    typed;
		result_t                               res;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [spq_pkg::S_DATA_W-1:0]   s_tdata;
	logic [0:0]                     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [spq_pkg::M_DATA_W-1:0]   m_tdata;

	// predictor state
	logic [spq_pkg::ITEM_W-1:0]           held_item [CAPACITY];
	logic signed [spq_pkg::IN_PRIO_W-1:0] held_prio [CAPACITY];
	int                                   held;

	result_t   pending_results [$];
	stim_row_t directed_rows [$];
	int        err_count;
	int        burst_left;

	sorted_priority_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(string field, int got, int want);
		err_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
	endtask

	// PRIORITY_BITS equals the input width here, so the wrap is the identity.
	function automatic result_t queue_step(spq_pkg::cmd_t c, logic [spq_pkg::ITEM_W-1:0] item,
			logic signed [spq_pkg::IN_PRIO_W-1:0] prio);
		result_t r;
		int pos;
		r.item_out = '0;
		r.status   = spq_pkg::ST_OK;
		if (c == spq_pkg::CMD_DEQ) begin
			if (held == 0) begin
				r.item_out = spq_pkg::EMPTY_ITEM;
				r.status   = spq_pkg::ST_EMPTY;
			end else begin
				r.item_out = held_item[0];
				for (int i = 1; i < held; i++) begin
					held_item[i-1] = held_item[i];
					held_prio[i-1] = held_prio[i];
				end
				held--;
			end
		end else if (held >= CAPACITY) begin
			r.status = spq_pkg::ST_FULL;
		end else begin
			// ties never displace the head, but go ahead of equal entries behind it
			if (held == 0 || prio < held_prio[0]) begin
				pos = 0;
			end else begin
				pos = 1;
				while (pos < held && prio > held_prio[pos])
					pos++;
			end
			for (int i = held; i > pos; i--) begin
				held_item[i] = held_item[i-1];
				held_prio[i] = held_prio[i-1];
			end
			held_item[pos] = item;
			held_prio[pos] = prio;
			held++;
		end
		r.fill = spq_pkg::FILL_W'(held);
		return r;
	endfunction

	task automatic send_beat(spq_pkg::cmd_t c, logic [spq_pkg::ITEM_W-1:0] item,
			logic [spq_pkg::IN_PRIO_W-1:0] prio, bit typed, result_t typed_res);
		result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {prio, item};
		s_tuser  <= c;
		do @(posedge clk); while (!s_tready);
		r = queue_step(c, item, prio);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic add_row(spq_pkg::cmd_t c, logic [spq_pkg::ITEM_W-1:0] item,
			logic [spq_pkg::IN_PRIO_W-1:0] prio, bit typed = 1'b0,
			logic [spq_pkg::ITEM_W-1:0] e_item = '0,
			spq_pkg::status_t e_st = spq_pkg::ST_OK,
			logic [spq_pkg::FILL_W-1:0] e_fill = '0);
		stim_row_t row;
		row.cmd          = c;
		row.item         = item;
		row.prio         = prio;
		row.typed        = typed;
		row.res.item_out = e_item;
		row.res.status   = e_st;
		row.res.fill     = e_fill;
		directed_rows.push_back(row);
	endtask

	function automatic logic [spq_pkg::IN_PRIO_W-1:0] rand_priority();
		logic [spq_pkg::IN_PRIO_W-1:0] corner [6];
		corner = '{16'h8000, 16'h7FFF, 16'h8001, 16'h7FFE, 16'h0000, 16'hFFFF};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: rand_priority = spq_pkg::IN_PRIO_W'($urandom_range(0, 8) - 4);
			4, 5:       rand_priority = corner[$urandom_range(0, 5)];
			default:    rand_priority = spq_pkg::IN_PRIO_W'($urandom);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", int'(m_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] != want.item_out)
					report_mismatch("item_out", int'(m_tdata[7:0]), int'(want.item_out));
				if (m_tdata[9:8] != want.status)
					report_mismatch("status", int'(m_tdata[9:8]), int'(want.status));
				if (m_tdata[14:10] != want.fill)
					report_mismatch("fill_count", int'(m_tdata[14:10]), int'(want.fill));
				if (m_tdata[15] != 1'b0)
					report_mismatch("pad", int'(m_tdata[15]), 0);
			end
		end
	end

	// receiver: segments of steady, random and sparse ready, plus one long hold-off
	initial begin
		int seg;
		int seg_len;
		int mode;
		m_tready = 1'b0;
		seg      = 0;
		@(posedge arst_n);
		forever begin
			if (seg == 4) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			mode    = $urandom_range(0, 2);
			seg_len = $urandom_range(20, 200);
			repeat (seg_len) begin
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
			seg++;
		end
	end

	// stimulus
	initial begin
		result_t none;
		int sent;
		int phase_left;
		int enq_pct;
		spq_pkg::cmd_t c;
		none       = '0;
		err_count  = 0;
		held       = 0;
		burst_left = 0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = spq_pkg::CMD_ENQ;

		add_row(spq_pkg::CMD_DEQ, 8'hFF, 16'hFFFF, 1'b1, spq_pkg::EMPTY_ITEM,
			spq_pkg::ST_EMPTY, 5'd0);
		add_row(spq_pkg::CMD_ENQ, 8'hFF, 16'h0000, 1'b1, 8'h00, spq_pkg::ST_OK, 5'd1);
		add_row(spq_pkg::CMD_ENQ, 8'h00, 16'h0000);   // tie with head goes behind it
		add_row(spq_pkg::CMD_ENQ, 8'h11, 16'h8000);   // new head
		add_row(spq_pkg::CMD_ENQ, 8'h22, 16'h7FFF);
		add_row(spq_pkg::CMD_ENQ, 8'h33, 16'h8000);   // tie with most negative head
		add_row(spq_pkg::CMD_ENQ, 8'h44, 16'h7FFF);   // tie at tail goes ahead of equal entry
		add_row(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);
		add_row(spq_pkg::CMD_DEQ, 8'h55, 16'hAAAA);
		for (int i = 0; i < 12; i++)
			add_row(spq_pkg::CMD_ENQ, 8'h80 + i[7:0],
				(i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'h7FFF :
				spq_pkg::IN_PRIO_W'(i - 6));
		add_row(spq_pkg::CMD_ENQ, 8'hAA, 16'hFFFB, 1'b1, 8'h00, spq_pkg::ST_FULL, 5'd16);
		add_row(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);
		add_row(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);
		add_row(spq_pkg::CMD_DEQ, 8'h00, 16'h0000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_beat(directed_rows[k].cmd, directed_rows[k].item, directed_rows[k].prio,
				directed_rows[k].typed, directed_rows[k].res);

		// phases biased toward filling, draining or churning the queue
		sent       = 0;
		phase_left = 0;
		enq_pct    = 50;
		while (sent < RAND_BEATS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(30, 60);
				case ($urandom_range(0, 3))
					0:       enq_pct = 85;
					1:       enq_pct = 15;
					2:       enq_pct = 50;
					default: enq_pct = 65;
				endcase
			end
			c = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
			send_beat(c, spq_pkg::ITEM_W'($urandom_range(0, 255)), rand_priority(),
				1'b0, none);
			phase_left--;
			sent++;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
